/* rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed widths for the sliding window maximum filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int VALUE_W = 16;
    localparam int CFG_W   = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRONT_REQ,
        S_FRONT_CHK,
        S_BACK_REQ,
        S_BACK_CHK,
        S_PUSH,
        S_OUT_REQ,
        S_OUT_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic rd_front;
        logic rd_back;
        logic chk_front;
        logic chk_back;
        logic push;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic smaller;
        logic emit;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer for one sample: front expiry, back drops, append, result read.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire swm_pkg::t_sts i_sts,
    output swm_pkg::t_cmd      o_cmd
);
    import swm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_FRONT_REQ;
            end
            S_FRONT_REQ: begin
                n_state = i_sts.empty ? S_PUSH : S_FRONT_CHK;
            end
            S_FRONT_CHK: begin
                n_state = S_BACK_REQ;
            end
            S_BACK_REQ: begin
                n_state = i_sts.empty ? S_PUSH : S_BACK_CHK;
            end
            S_BACK_CHK: begin
                n_state = i_sts.smaller ? S_BACK_REQ : S_PUSH;
            end
            S_PUSH: begin
                n_state = i_sts.emit ? S_OUT_REQ : S_IDLE;
            end
            S_OUT_REQ: begin
                n_state = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_FRONT_REQ: begin
                o_cmd.rd_front = !i_sts.empty;
            end
            S_FRONT_CHK: begin
                o_cmd.chk_front = 1'b1;
            end
            S_BACK_REQ: begin
                o_cmd.rd_back = !i_sts.empty;
            end
            S_BACK_CHK: begin
                o_cmd.chk_back = 1'b1;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
            end
            S_OUT_REQ: begin
                o_cmd.rd_front = 1'b1;
            end
            S_OUT_LOAD: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/swm_dpath.sv */
// ----------------------------------------------------------------------------
// swm_dpath
// Deque storage, head/count pointers, position counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_dpath #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire swm_pkg::t_cmd                 i_cmd,
    output swm_pkg::t_sts                      o_sts,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0] i_win,
    input  wire logic signed [swm_pkg::VALUE_W-1:0] i_sample_value,
    input  wire logic                          i_starts_sequence,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [swm_pkg::VALUE_W-1:0] o_window_max
);
    import swm_pkg::*;

    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int POS_W   = $clog2(2 * MAX_WINDOW);
    localparam int POS_MOD = 2 * MAX_WINDOW;
    localparam int ENT_W   = VALUE_W + POS_W;

    logic [ENT_W-1:0] mem [MAX_WINDOW];

    logic [IDX_W-1:0]          r_head;
    logic [CNT_W-1:0]          r_count;
    logic [POS_W-1:0]          r_pos;
    logic [CNT_W-1:0]          r_seen;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_sample;
    logic signed [VALUE_W-1:0] r_rd_value;
    logic [POS_W-1:0]          r_rd_pos;
    logic signed [VALUE_W-1:0] r_out_data;

    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] tail_slot;
    logic [IDX_W-1:0] wr_slot;
    logic [IDX_W-1:0] rd_slot;
    logic             full;
    logic             expired;
    logic [POS_W:0]   age;
    logic [POS_W-1:0] pos_inc;
    logic [CNT_W-1:0] n_seen;

    // (head + off) modulo MAX_WINDOW; off never exceeds MAX_WINDOW
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [POS_W-1:0] sum;
        sum = POS_W'(head) + POS_W'(off);
        if (sum >= POS_W'(MAX_WINDOW)) sum = sum - POS_W'(MAX_WINDOW);
        return sum[IDX_W-1:0];
    endfunction

    always_comb begin
        head_inc  = (r_head == IDX_W'(MAX_WINDOW - 1)) ? '0 : r_head + IDX_W'(1);
        back_slot = slot_of(r_head, r_count - CNT_W'(1));
        tail_slot = slot_of(r_head, r_count);
        full      = (r_count == CNT_W'(MAX_WINDOW));
        // a full deque overwrites its oldest entry in place
        wr_slot   = full ? r_head : tail_slot;
        rd_slot   = i_cmd.rd_back ? back_slot : r_head;

        if (r_pos >= r_rd_pos) age = {1'b0, r_pos} - {1'b0, r_rd_pos};
        else age = {1'b0, r_pos} + (POS_W+1)'(POS_MOD) - {1'b0, r_rd_pos};
        expired = (age >= (POS_W+1)'(i_win));

        pos_inc = (r_pos == POS_W'(POS_MOD - 1)) ? '0 : r_pos + POS_W'(1);
        n_seen  = (r_seen < i_win) ? r_seen + CNT_W'(1) : r_seen;

        o_sts.empty    = (r_count == '0);
        o_sts.smaller  = (r_rd_value < r_sample);
        o_sts.emit     = (n_seen >= i_win);
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_starts_sequence) begin
                r_head  <= '0;
                r_count <= '0;
                r_pos   <= '0;
                r_seen  <= '0;
            end
            if (i_cmd.chk_front && expired) begin
                r_head  <= head_inc;
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.chk_back && o_sts.smaller) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.push) begin
                if (full) r_head <= head_inc;
                else r_count <= r_count + CNT_W'(1);
                r_pos  <= pos_inc;
                r_seen <= n_seen;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_sample <= i_sample_value;
        if (i_cmd.load_out) r_out_data <= r_rd_value;
    end

    // deque storage: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) mem[wr_slot] <= {r_sample, r_pos};
        if (i_cmd.rd_front || i_cmd.rd_back) begin
            {r_rd_value, r_rd_pos} <= mem[rd_slot];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WINDOW))
        else $error("deque count above capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= IDX_W'(MAX_WINDOW - 1))
        else $error("deque head out of range");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_count != '0)
        else $error("deque empty after append");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid && (r_out_data == $past(r_rd_value)))
        else $error("result register not loaded from front entry");
`endif

endmodule

`default_nettype wire

/* rtl/sliding_window_maximum.sv */
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum over the last window_size samples, monotonic deque in RAM.
// One word in flight; its time grows with each back entry dropped, since the
//   single-port deque RAM is read once per compare (one compare per read).
// Result: o_out_valid follows the front read and the load of the result
//   register, plus any i_out_stall wait while an older result is held.
// Reset: synchronous, active low; deque empty, counters zero, window 1.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]          i_cfg_window_size,
    // sample input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [swm_pkg::VALUE_W-1:0] i_sample_value,
    input  wire logic                               i_starts_sequence,
    // result output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [swm_pkg::VALUE_W-1:0]      o_window_max
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0] r_window_size;
    logic [CNT_W-1:0] w_win;
    t_cmd             cmd;
    t_sts             sts;

    // Window register: always ready; write it only while no word is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_size <= i_cfg_window_size;
        end
    end

    // Clamp the window into 1..MAX_WINDOW; the register keeps its raw bits.
    always_comb begin
        if (r_window_size == '0) begin
            w_win = CNT_W'(1);
        end else if (32'(r_window_size) > 32'(MAX_WINDOW)) begin
            w_win = CNT_W'(MAX_WINDOW);
        end else begin
            w_win = CNT_W'(r_window_size);
        end
    end

    // Sequencer: one word in flight; the result register lets the next word
    // enter while a finished maximum still waits on i_out_stall.
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Deque RAM, pointers, position/sample counters, result register.
    swm_dpath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_win             (w_win),
        .i_sample_value    (i_sample_value),
        .i_starts_sequence (i_starts_sequence),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_window_max      (o_window_max)
    );

endmodule

`default_nettype wire

/* dv/tb_sliding_window_maximum.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_maximum
// Self-checking bench for the sliding window maximum filter. A directed table
// covers the window reset value, out-of-range windows, sample extremes, expiry
// and a window change in the middle of a sequence. Random phases follow, each
// under a fresh window setting. Every accepted word runs through a local
// monotonic-deque predictor, and each result word is compared in order.
// ----------------------------------------------------------------------------

module tb_sliding_window_maximum;

    import swm_pkg::*;

    localparam int      DEPTH         = 64;
    localparam int      IDX_W         = $clog2(DEPTH);
    localparam int      POS_W         = IDX_W + 1;      // positions wrap at 2*DEPTH
    localparam int      RANDOM_WORDS  = 1000;
    // worst case per word: every back entry of a full deque dropped, with margin
    localparam int      DRAIN_CYCLES  = 8 + 2 * DEPTH + 16;
    localparam int      HOLDOFF_CYCLES = 400;
    localparam longint  LIMIT_NS      = 64'd20_000_000;

    typedef logic signed [VALUE_W-1:0] t_sample;
    typedef logic [CFG_W-1:0]          t_window;

    localparam t_sample SAMPLE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // shapes of the random sample streams
    typedef enum int {
        PAT_RANDOM,     // full range, every bit toggles
        PAT_TIES,       // narrow range around zero, lots of equal values
        PAT_FALLING,    // long falling runs with rare jumps up: deep deque, bulk pops
        PAT_EXTREMES    // rails, zero and minus one
    } t_pattern;

    typedef struct {
        bit      set_window;
        t_window window;
        t_sample value;
        bit      start;
        bit      has_max;       // result typed in by hand
        t_sample known_max;
    } t_directed_row;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic    i_clk             = 1'b0;
    logic    i_rst_n           = 1'b0;
    logic    i_cfg_valid       = 1'b0;
    t_window i_cfg_window_size = '0;
    logic    i_in_valid        = 1'b0;
    t_sample i_sample_value    = '0;
    logic    i_starts_sequence = 1'b0;
    logic    i_out_stall       = 1'b0;
    logic    o_cfg_ready;
    logic    o_in_stall;
    logic    o_out_valid;
    t_sample o_window_max;

    // hand-typed expectation that travels with the word on the input
    logic    row_has_max = 1'b0;
    t_sample row_max     = '0;

    always #5 i_clk = ~i_clk;

    sliding_window_maximum #(
        .MAX_WINDOW (DEPTH)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sample_value    (i_sample_value),
        .i_starts_sequence (i_starts_sequence),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_window_max      (o_window_max)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a copy of the deque, its counters and the window
    // ------------------------------------------------------------------------
    t_sample           cand_value [DEPTH];
    logic [POS_W-1:0]  cand_pos   [DEPTH];
    logic [IDX_W-1:0]  dq_head;
    logic [POS_W-1:0]  dq_count;
    logic [POS_W-1:0]  next_pos;
    logic [POS_W-1:0]  seen_count;
    t_window           window_reg;

    t_sample           window_max_queue [$];
    int                mismatch_count = 0;
    int                accepted_words = 0;
    t_directed_row     directed_rows  [$];

    // Take one sample into the deque and report the window maximum, if the
    // sequence is long enough to have one.
    task automatic advance_window_max(input t_sample value, input bit start,
                                      output bit has_max, output t_sample max_val);
        int               win;
        logic [POS_W-1:0] age;
        logic [IDX_W-1:0] slot;
        begin
            // zero acts as one, anything past the deque depth is clamped
            if (window_reg == '0) begin
                win = 1;
            end else if (int'(window_reg) > DEPTH) begin
                win = DEPTH;
            end else begin
                win = int'(window_reg);
            end

            if (start) begin
                dq_head    = '0;
                dq_count   = '0;
                next_pos   = '0;
                seen_count = '0;
            end

            // expire at most one front entry; the position difference wraps
            if (dq_count != '0) begin
                age = next_pos - cand_pos[dq_head];
                if (int'(age) >= win) begin
                    dq_head  = dq_head + 1'b1;
                    dq_count = dq_count - 1'b1;
                end
            end

            // pop back entries strictly below the new sample; ties stay
            while (dq_count != '0 &&
                   cand_value[dq_head + IDX_W'(dq_count - 1'b1)] < value) begin
                dq_count = dq_count - 1'b1;
            end

            // full deque: drop the oldest to make room
            if (int'(dq_count) >= DEPTH) begin
                dq_head  = dq_head + 1'b1;
                dq_count = dq_count - 1'b1;
            end

            slot             = dq_head + IDX_W'(dq_count);
            cand_value[slot] = value;
            cand_pos[slot]   = next_pos;
            dq_count         = dq_count + 1'b1;
            next_pos         = next_pos + 1'b1;

            if (int'(seen_count) < win) begin
                seen_count = seen_count + 1'b1;
            end
            has_max = (int'(seen_count) >= win);
            max_val = cand_value[dq_head];
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: all handshakes are sampled at the rising edge, before the
    // driver's nonblocking updates land
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit      got_max;
        t_sample predicted;
        t_sample expected;
        if (!i_rst_n) begin
            dq_head    = '0;
            dq_count   = '0;
            next_pos   = '0;
            seen_count = '0;
            window_reg = t_window'(1);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                window_reg = i_cfg_window_size;
            end

            if (i_in_valid && !o_in_stall) begin
                advance_window_max(i_sample_value, i_starts_sequence, got_max, predicted);
                // a hand-typed value takes the place of the predicted one
                if (row_has_max) begin
                    window_max_queue.insert(window_max_queue.size(), row_max);
                end else if (got_max) begin
                    window_max_queue.insert(window_max_queue.size(), predicted);
                end
                accepted_words++;
            end

            if (o_out_valid && !i_out_stall) begin
                if (window_max_queue.size() == 0) begin
                    $error("window_max: no word expected, got %0d", o_window_max);
                    mismatch_count++;
                end else begin
                    expected = window_max_queue[0];
                    window_max_queue.delete(0);
                    if (o_window_max !== expected) begin
                        $error("window_max: expected %0d, got %0d", expected, o_window_max);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: one long hold-off once traffic is flowing, so the block fills
    // up and stalls its input; otherwise quiet stretches and stall bursts
    // ------------------------------------------------------------------------
    initial begin
        bit held_off;
        int len;
        held_off = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held_off && accepted_words >= 30) begin
                i_out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                held_off = 1'b1;
            end
            if ($urandom_range(0, 9) < 3) begin
                // take everything for a while
                i_out_stall <= 1'b0;
                repeat ($urandom_range(20, 100)) @(posedge i_clk);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(1, 3);
                i_out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_window pick_window();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_window'(DEPTH);
            3:       return t_window'($urandom_range(DEPTH + 1, 126));
            4:       return t_window'($urandom_range(9, DEPTH - 1));
            default: return t_window'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic t_sample next_sample(input t_pattern pattern, input t_sample prev);
        int p;
        case (pattern)
            PAT_RANDOM: begin
                return t_sample'($urandom);
            end
            PAT_TIES: begin
                return t_sample'(int'($urandom_range(0, 6)) - 3);
            end
            PAT_FALLING: begin
                // rare jump up clears a deep deque in one word
                if ($urandom_range(0, 19) == 0) return t_sample'($urandom);
                p = int'(prev) - int'($urandom_range(0, 200));
                if (p < int'(SAMPLE_MIN)) p = int'(SAMPLE_MAX);
                return t_sample'(p);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Offer one word and hold it until the block takes it. The valid stays
    // high on back-to-back words.
    task automatic send_word(input t_sample value, input bit start, input bit has_max,
                             input t_sample known_max, input bit no_gaps);
        int gap;
        begin
            gap = no_gaps ? 0 : pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_sample_value    <= value;
            i_starts_sequence <= start;
            row_has_max       <= has_max;
            row_max           <= known_max;
            i_in_valid        <= 1'b1;
            do @(posedge i_clk); while (o_in_stall);
        end
    endtask

    // Drop the input, wait for every expected word, then let a word that
    // produces no result finish inside the block.
    task automatic drain();
        begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (window_max_queue.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_window(input t_window window);
        begin
            i_cfg_window_size <= window;
            i_cfg_valid       <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic add_row(input bit set_window, input t_window window, input t_sample value,
                           input bit start, input bit has_max, input t_sample known_max);
        t_directed_row row;
        begin
            row.set_window = set_window;
            row.window     = window;
            row.value      = value;
            row.start      = start;
            row.has_max    = has_max;
            row.known_max  = known_max;
            directed_rows.insert(directed_rows.size(), row);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int       sent;
        int       len;
        bit       quiet;
        bit       start;
        t_window  window;
        t_sample  value;
        t_pattern pattern;

        // Window is one out of reset: each word comes straight back.
        add_row(0, '0, '0,                 1, 1, '0);
        add_row(0, '0, SAMPLE_MAX,         0, 1, SAMPLE_MAX);
        add_row(0, '0, SAMPLE_MIN,         0, 1, SAMPLE_MIN);
        add_row(0, '0, t_sample'(16'h5555), 0, 1, t_sample'(16'h5555));
        add_row(0, '0, t_sample'(16'haaaa), 0, 1, t_sample'(16'haaaa));
        // Zero window behaves as one.
        add_row(1, '0, '0,                 0, 0, '0);
        add_row(0, '0, t_sample'(5),       1, 1, t_sample'(5));
        add_row(0, '0, t_sample'(-7),      0, 1, t_sample'(-7));
        // Window of three: fill, then watch the peak expire; equal values stay.
        add_row(1, t_window'(3), '0,       0, 0, '0);
        add_row(0, '0, t_sample'(10),      1, 0, '0);
        add_row(0, '0, t_sample'(20),      0, 0, '0);
        add_row(0, '0, t_sample'(15),      0, 1, t_sample'(20));
        add_row(0, '0, t_sample'(5),       0, 1, t_sample'(20));
        add_row(0, '0, t_sample'(3),       0, 1, t_sample'(15));
        add_row(0, '0, t_sample'(3),       0, 1, t_sample'(5));
        add_row(0, '0, SAMPLE_MAX,         0, 1, SAMPLE_MAX);
        // Shrink the window mid-sequence; no start, the deque carries over.
        add_row(1, t_window'(2), '0,       0, 0, '0);
        add_row(0, '0, SAMPLE_MIN,         0, 0, '0);
        add_row(0, '0, SAMPLE_MIN,         0, 0, '0);
        // Window beyond the deque depth is clamped: too short for a result.
        add_row(1, '1, '0,                 0, 0, '0);
        add_row(0, '0, t_sample'(100),     1, 0, '0);
        add_row(0, '0, t_sample'(200),     0, 0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_window) begin
                drain();
                write_window(directed_rows[i].window);
            end else begin
                send_word(directed_rows[i].value, directed_rows[i].start,
                          directed_rows[i].has_max, directed_rows[i].known_max, 1'b0);
            end
        end

        // Random phases: new window each time, mostly a fresh sequence,
        // sometimes carrying the old sequence into the new window.
        sent  = 0;
        value = '0;
        while (sent < RANDOM_WORDS) begin
            drain();
            window = pick_window();
            write_window(window);
            pattern = t_pattern'($urandom_range(0, 3));
            quiet   = ($urandom_range(0, 3) == 0);
            if (int'(window) >= DEPTH) begin
                // long runs so the deque fills to depth and entries expire
                len = $urandom_range(70, 140);
                if ($urandom_range(0, 1) == 0) pattern = PAT_FALLING;
            end else begin
                len = $urandom_range(5, 40);
            end
            for (int k = 0; k < len; k++) begin
                start = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0);
                value = next_sample(pattern, value);
                send_word(value, start, 1'b0, '0, quiet);
                sent++;
            end
        end

        drain();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hang guard
    initial begin
        #LIMIT_NS;
        $display("FAILURE");
        $finish;
    end

endmodule
